// ===== rtl/tmf_pkg.sv =====
// Shared types and constants of the two-stage trimmed mean filter.
package tmf_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MV_BITS     = 13;

    typedef logic [SAMPLE_BITS-1:0] t_code;
    typedef logic [MV_BITS-1:0]     t_mv;

    localparam t_code SAMPLE_MAX   = '1;
    localparam t_mv   REF_MV_RESET = 13'd3300;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_BLK,
        BK_STORE,
        BK_SCAN,
        BK_TRIM,
        BK_DIV_WIN,
        BK_MUL,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic div_start;
        logic div_sel;
        logic ring_we;
        logic scan_en;
        logic out_load;
        logic out_valid;
    } t_back_ctl;

endpackage

// ===== rtl/tmf_div.sv =====
// Constant divider for the block and ring means, built as a reciprocal multiplication.
module tmf_div #(
    parameter int DW      = 17,
    parameter int BLK_DIV = 28,
    parameter int WIN_DIV = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_sel,
    input  logic [DW-1:0] i_dividend,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int DL     = $clog2((BLK_DIV > WIN_DIV) ? BLK_DIV : WIN_DIV);
    localparam int SHIFT  = DW + DL;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = DW + RCP_W;
    localparam logic [RCP_W-1:0] RCP_BLK = RCP_W'(((1 << SHIFT) + BLK_DIV - 1) / BLK_DIV);
    localparam logic [RCP_W-1:0] RCP_WIN = RCP_W'(((1 << SHIFT) + WIN_DIV - 1) / WIN_DIV);

    logic              r_busy;
    logic              r_done;
    logic              r_sel;
    logic [DW-1:0]     r_dvd;
    logic [PROD_W-1:0] r_prod;
    logic [RCP_W-1:0]  rcp;

    assign rcp = r_sel ? RCP_WIN : RCP_BLK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_sel <= i_sel;
        end
        if (r_busy) begin
            r_prod <= PROD_W'(r_dvd) * PROD_W'(rcp);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_prod[SHIFT +: DW];

endmodule

// ===== rtl/tmf_queue.sv =====
// Two-entry queue that carries finished block statistics to the back end.
module tmf_queue import tmf_pkg::*; #(
    parameter int DATA_W = 82
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("Queue read while empty.");

endmodule

// ===== rtl/tmf_front.sv =====
// Front end: accepts sample pairs and keeps the running block sum, maximum and minimum.
module tmf_front import tmf_pkg::*; #(
    parameter int BLOCK_LEN = 30
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_code i_sample_first,
    input  t_code i_sample_second,
    input  logic  i_q_full,
    output logic  o_push,
    output logic [2*(SAMPLE_BITS+$clog2(BLOCK_LEN)+2*SAMPLE_BITS)-1:0] o_push_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN);
    localparam int ENT_W = SUM_W + 2 * SAMPLE_BITS;
    localparam int POS_W = $clog2(BLOCK_LEN);

    logic [POS_W-1:0] r_pos;
    logic [SUM_W-1:0] r_sum [2];
    logic [SUM_W-1:0] n_sum [2];
    t_code            r_max [2];
    t_code            n_max [2];
    t_code            r_min [2];
    t_code            n_min [2];
    t_code            smp   [2];
    logic             last;
    logic             accept;

    assign smp[0] = i_sample_first;
    assign smp[1] = i_sample_second;

    assign last    = (r_pos == POS_W'(BLOCK_LEN - 1));
    assign o_stall = last && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = accept && last;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_sum[c] = r_sum[c] + SUM_W'(smp[c]);
            n_max[c] = (smp[c] > r_max[c]) ? smp[c] : r_max[c];
            n_min[c] = (smp[c] < r_min[c]) ? smp[c] : r_min[c];
            o_push_data[c*ENT_W +: ENT_W] = {n_sum[c], n_max[c], n_min[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int c = 0; c < 2; c++) begin
                r_sum[c] <= '0;
                r_max[c] <= '0;
                r_min[c] <= SAMPLE_MAX;
            end
        end else if (accept) begin
            if (last) begin
                r_pos <= '0;
                for (int c = 0; c < 2; c++) begin
                    r_sum[c] <= '0;
                    r_max[c] <= '0;
                    r_min[c] <= SAMPLE_MAX;
                end
            end else begin
                r_pos <= r_pos + POS_W'(1);
                for (int c = 0; c < 2; c++) begin
                    r_sum[c] <= n_sum[c];
                    r_max[c] <= n_max[c];
                    r_min[c] <= n_min[c];
                end
            end
        end
    end

endmodule

// ===== rtl/tmf_back.sv =====
// Back end: block mean, ring update, ring trimmed mean and millivolt scaling.
module tmf_back import tmf_pkg::*; #(
    parameter int BLOCK_LEN  = 30,
    parameter int WINDOW_LEN = 5
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  logic [2*(SAMPLE_BITS+$clog2(BLOCK_LEN)+2*SAMPLE_BITS)-1:0] i_q_data,
    output logic  o_q_pop,
    input  t_mv   i_ref_mv,
    output logic  o_valid,
    input  logic  i_stall,
    output t_code o_filtered_first,
    output t_code o_filtered_second,
    output t_mv   o_millivolts_first,
    output t_mv   o_millivolts_second
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(BLOCK_LEN);
    localparam int ENT_W  = SUM_W + 2 * SAMPLE_BITS;
    localparam int RSUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int DW     = (SUM_W > RSUM_W) ? SUM_W : RSUM_W;
    localparam int WP_W   = $clog2(WINDOW_LEN);
    localparam int PROD_W = SAMPLE_BITS + MV_BITS;

    t_back_state       r_state;
    t_back_state       n_state;
    t_back_ctl         ctl;

    logic [SUM_W-1:0]  q_sum    [2];
    t_code             q_max    [2];
    t_code             q_min    [2];
    logic [SUM_W-1:0]  blk_diff [2];
    logic [RSUM_W-1:0] win_diff [2];
    logic [DW-1:0]     dividend [2];
    logic [DW-1:0]     quo      [2];
    logic [1:0]        done;
    logic              div_done;
    logic [PROD_W-1:0] prod     [2];

    t_code             r_ring   [2][WINDOW_LEN];
    logic [WP_W-1:0]   r_wpos;
    logic [WP_W-1:0]   r_scan;
    logic [RSUM_W-1:0] r_rsum   [2];
    t_code             r_hi     [2];
    t_code             r_lo     [2];
    t_code             r_filt   [2];
    t_mv               r_mv     [2];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            q_min[c]    = i_q_data[c*ENT_W +: SAMPLE_BITS];
            q_max[c]    = i_q_data[c*ENT_W + SAMPLE_BITS +: SAMPLE_BITS];
            q_sum[c]    = i_q_data[c*ENT_W + 2*SAMPLE_BITS +: SUM_W];
            blk_diff[c] = q_sum[c] - SUM_W'(q_max[c]) - SUM_W'(q_min[c]);
            win_diff[c] = r_rsum[c] - RSUM_W'(r_hi[c]) - RSUM_W'(r_lo[c]);
            dividend[c] = ctl.div_sel ? DW'(win_diff[c]) : DW'(blk_diff[c]);
            prod[c]     = PROD_W'(quo[c][SAMPLE_BITS-1:0]) * PROD_W'(i_ref_mv);
        end
    end

    assign div_done = &done;

    for (genvar g = 0; g < 2; g++) begin : g_div
        tmf_div #(
            .DW      (DW),
            .BLK_DIV (BLOCK_LEN - 2),
            .WIN_DIV (WINDOW_LEN - 2)
        ) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (ctl.div_start),
            .i_sel      (ctl.div_sel),
            .i_dividend (dividend[g]),
            .o_done     (done[g]),
            .o_quotient (quo[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_DIV_BLK;
                end
            end
            BK_DIV_BLK: begin
                if (div_done) begin
                    n_state = BK_STORE;
                end
            end
            BK_STORE: begin
                n_state = BK_SCAN;
            end
            BK_SCAN: begin
                if (r_scan == WP_W'(WINDOW_LEN - 1)) begin
                    n_state = BK_TRIM;
                end
            end
            BK_TRIM: begin
                n_state = BK_DIV_WIN;
            end
            BK_DIV_WIN: begin
                if (div_done) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (!i_stall) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        case (r_state)
            BK_IDLE: begin
                ctl.pop       = i_q_valid;
                ctl.div_start = i_q_valid;
            end
            BK_STORE: begin
                ctl.ring_we = 1'b1;
            end
            BK_SCAN: begin
                ctl.scan_en = 1'b1;
            end
            BK_TRIM: begin
                ctl.div_start = 1'b1;
                ctl.div_sel   = 1'b1;
            end
            BK_MUL: begin
                ctl.out_load = 1'b1;
            end
            BK_OUT: begin
                ctl.out_valid = 1'b1;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_wpos  <= '0;
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    r_ring[c][i] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (ctl.ring_we) begin
                for (int c = 0; c < 2; c++) begin
                    r_ring[c][r_wpos] <= quo[c][SAMPLE_BITS-1:0];
                end
                if (r_wpos == WP_W'(WINDOW_LEN - 1)) begin
                    r_wpos <= '0;
                end else begin
                    r_wpos <= r_wpos + WP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ring_we) begin
            r_scan <= '0;
            for (int c = 0; c < 2; c++) begin
                r_rsum[c] <= '0;
                r_hi[c]   <= '0;
                r_lo[c]   <= SAMPLE_MAX;
            end
        end else if (ctl.scan_en) begin
            r_scan <= r_scan + WP_W'(1);
            for (int c = 0; c < 2; c++) begin
                r_rsum[c] <= r_rsum[c] + RSUM_W'(r_ring[c][r_scan]);
                if (r_ring[c][r_scan] > r_hi[c]) begin
                    r_hi[c] <= r_ring[c][r_scan];
                end
                if (r_ring[c][r_scan] < r_lo[c]) begin
                    r_lo[c] <= r_ring[c][r_scan];
                end
            end
        end
        if (ctl.out_load) begin
            for (int c = 0; c < 2; c++) begin
                r_filt[c] <= quo[c][SAMPLE_BITS-1:0];
                r_mv[c]   <= prod[c][SAMPLE_BITS +: MV_BITS];
            end
        end
    end

    assign o_q_pop             = ctl.pop;
    assign o_valid             = ctl.out_valid;
    assign o_filtered_first    = r_filt[0];
    assign o_filtered_second   = r_filt[1];
    assign o_millivolts_first  = r_mv[0];
    assign o_millivolts_second = r_mv[1];

    a_blk_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && i_q_valid) |->
            q_sum[0] >= SUM_W'(q_max[0]) + SUM_W'(q_min[0]) &&
            q_sum[1] >= SUM_W'(q_max[1]) + SUM_W'(q_min[1]))
        else $error("Block sum below its maximum plus minimum.");

    a_win_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_TRIM) |->
            r_rsum[0] >= RSUM_W'(r_hi[0]) + RSUM_W'(r_lo[0]) &&
            r_rsum[1] >= RSUM_W'(r_hi[1]) + RSUM_W'(r_lo[1]))
        else $error("Ring sum below its maximum plus minimum.");

    a_wpos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ring_we |=> r_wpos != $past(r_wpos))
        else $error("Ring position did not advance after a write.");

endmodule

// ===== rtl/two_stage_trimmed_mean_filter_core.sv =====
// Two-stage trimmed mean filter for two converter channels, top level.
// The block takes one sample pair per cycle when it does not stall. Every BLOCK_LEN
// items it forms each channel's block trimmed mean, pushes it into a WINDOW_LEN-entry
// ring and delivers one item with the ring trimmed mean and its millivolt value. For
// each block the back end divides the block sum, writes the ring, scans it, divides
// the ring sum, both divisions by reciprocal multiplication, and scales to millivolts;
// it then holds the finished item while the receiver stalls. A two-entry queue
// between front and back absorbs the difference in pace, and the last item
// of a block is stalled only when that queue is full. No result item comes out for
// the other items.
module two_stage_trimmed_mean_filter_core import tmf_pkg::*; #(
    parameter int BLOCK_LEN  = 30,
    parameter int WINDOW_LEN = 5
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  t_mv   i_cfg_wdata,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_code i_sample_first,
    input  t_code i_sample_second,
    output logic  o_valid,
    input  logic  i_stall,
    output t_code o_filtered_first,
    output t_code o_filtered_second,
    output t_mv   o_millivolts_first,
    output t_mv   o_millivolts_second
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_LEN);
    localparam int Q_W   = 2 * (SUM_W + 2 * SAMPLE_BITS);

    t_mv            r_ref_mv;
    logic           q_push;
    logic [Q_W-1:0] q_wdata;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    logic [Q_W-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv <= REF_MV_RESET;
        end else if (i_cfg_we) begin
            r_ref_mv <= i_cfg_wdata;
        end
    end

    tmf_front #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_push_data     (q_wdata)
    );

    tmf_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    tmf_back #(
        .BLOCK_LEN  (BLOCK_LEN),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_data            (q_rdata),
        .o_q_pop             (q_pop),
        .i_ref_mv            (r_ref_mv),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_filtered_first    (o_filtered_first),
        .o_filtered_second   (o_filtered_second),
        .o_millivolts_first  (o_millivolts_first),
        .o_millivolts_second (o_millivolts_second)
    );

endmodule
